// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define MFGP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MFGP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MFGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFGP_ASSERT_ALWAYS(lbl, prop, msg)
`define MFGP_ASSERT_SAME(lbl, ante, cons, msg)
`define MFGP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/mfgp_pkg.sv -----
// Shared types, constants, font table and microprogram of the glyph plotter.
package mfgp_pkg;

  localparam int STORED_ROWS_DEF   = 32;
  localparam int WORDS_PER_ROW_DEF = 16;
  localparam int WORD_W            = 16;
  localparam int GLYPH_COUNT       = 13;
  localparam int GLYPH_ROWS        = 5;
  localparam logic [7:0]  CMD_ROW_BASE = 8'h80;
  localparam logic [7:0]  CMD_COL_ZERO = 8'h80;
  localparam logic [15:0] DOT_MSB_MASK = 16'h8000;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PLOT    = 2'd1,
    OP_GLYPH   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_CLR     = 4'd1,
    ACT_RD_DOT  = 4'd2,
    ACT_WR_DOT  = 4'd3,
    ACT_GLY_ADV = 4'd4,
    ACT_EMIT_ROW = 4'd5,
    ACT_EMIT_COL = 4'd6,
    ACT_RD_WORD = 4'd7,
    ACT_EMIT_HI = 4'd8,
    ACT_EMIT_LO = 4'd9
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER      = 4'd0,
    C_ALWAYS     = 4'd1,
    C_DISPATCH   = 4'd2,
    C_CLR_MORE   = 4'd3,
    C_DOT_OFF    = 4'd4,
    C_BAD_GLYPH  = 4'd5,
    C_DOT_SKIP   = 4'd6,
    C_GLY_MORE   = 4'd7,
    C_ROW_BAD    = 4'd8,
    C_OUT_BUSY   = 4'd9,
    C_WORDS_MORE = 4'd10
  } cond_t;

  typedef logic [4:0] step_t;

  // Microprogram step addresses
  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_CLR       = 5'd1;
  localparam step_t S_CLR_DONE  = 5'd2;
  localparam step_t S_PLOT_RD   = 5'd3;
  localparam step_t S_PLOT_WR   = 5'd4;
  localparam step_t S_GLY_START = 5'd5;
  localparam step_t S_GLY_TEST  = 5'd6;
  localparam step_t S_GLY_WR    = 5'd7;
  localparam step_t S_GLY_NEXT  = 5'd8;
  localparam step_t S_GLY_DONE  = 5'd9;
  localparam step_t S_REF_START = 5'd10;
  localparam step_t S_REF_ROW   = 5'd11;
  localparam step_t S_REF_COL   = 5'd12;
  localparam step_t S_REF_RD    = 5'd13;
  localparam step_t S_REF_HI    = 5'd14;
  localparam step_t S_REF_LO    = 5'd15;
  localparam step_t S_REF_LOOP  = 5'd16;
  localparam step_t S_REF_DONE  = 5'd17;

  typedef struct packed {
    logic  take;
    act_t  act;
    cond_t cond;
    step_t target;
  } ucw_t;

  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    w.take   = 1'b0;
    w.act    = ACT_NONE;
    w.cond   = C_NEVER;
    w.target = S_IDLE;
    case (s)
      S_IDLE: begin
        w.take = 1'b1;
        w.cond = C_DISPATCH;
      end
      S_CLR: begin
        w.act = ACT_CLR; w.cond = C_CLR_MORE; w.target = S_CLR;
      end
      S_CLR_DONE:  w.cond = C_ALWAYS;
      S_PLOT_RD: begin
        w.act = ACT_RD_DOT; w.cond = C_DOT_OFF;
      end
      S_PLOT_WR: begin
        w.act = ACT_WR_DOT; w.cond = C_ALWAYS;
      end
      S_GLY_START: w.cond = C_BAD_GLYPH;
      S_GLY_TEST: begin
        w.act = ACT_RD_DOT; w.cond = C_DOT_SKIP; w.target = S_GLY_NEXT;
      end
      S_GLY_WR:    w.act = ACT_WR_DOT;
      S_GLY_NEXT: begin
        w.act = ACT_GLY_ADV; w.cond = C_GLY_MORE; w.target = S_GLY_TEST;
      end
      S_GLY_DONE:  w.cond = C_ALWAYS;
      S_REF_START: w.cond = C_ROW_BAD;
      S_REF_ROW: begin
        w.act = ACT_EMIT_ROW; w.cond = C_OUT_BUSY; w.target = S_REF_ROW;
      end
      S_REF_COL: begin
        w.act = ACT_EMIT_COL; w.cond = C_OUT_BUSY; w.target = S_REF_COL;
      end
      S_REF_RD:    w.act = ACT_RD_WORD;
      S_REF_HI: begin
        w.act = ACT_EMIT_HI; w.cond = C_OUT_BUSY; w.target = S_REF_HI;
      end
      S_REF_LO: begin
        w.act = ACT_EMIT_LO; w.cond = C_OUT_BUSY; w.target = S_REF_LO;
      end
      S_REF_LOOP: begin
        w.cond = C_WORDS_MORE; w.target = S_REF_RD;
      end
      S_REF_DONE:  w.cond = C_ALWAYS;
      default:     w.cond = C_ALWAYS;
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input op_t op);
    step_t s;
    unique case (op)
      OP_CLEAR:   s = S_CLR;
      OP_PLOT:    s = S_PLOT_RD;
      OP_GLYPH:   s = S_GLY_START;
      OP_REFRESH: s = S_REF_START;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

  // Font row pattern, rightmost dot in bit 0
  function automatic logic [7:0] font_row(input logic [3:0] code, input logic [2:0] row);
    logic [39:0] pat;
    case (code)
      4'd0:    pat = 40'h06_09_09_09_06;
      4'd1:    pat = 40'h02_06_02_02_07;
      4'd2:    pat = 40'h06_09_02_04_0F;
      4'd3:    pat = 40'h06_09_02_09_06;
      4'd4:    pat = 40'h02_06_0A_0F_02;
      4'd5:    pat = 40'h0E_08_0E_01_0E;
      4'd6:    pat = 40'h06_08_0E_09_06;
      4'd7:    pat = 40'h0F_01_02_04_04;
      4'd8:    pat = 40'h06_09_06_09_06;
      4'd9:    pat = 40'h06_09_07_01_06;
      4'd10:   pat = 40'h00_00_00_00_01;
      4'd11:   pat = 40'h00_01_00_01_00;
      default: pat = 40'h00_00_00_00_00;
    endcase
    case (row)
      3'd0:    return pat[39:32];
      3'd1:    return pat[31:24];
      3'd2:    return pat[23:16];
      3'd3:    return pat[15:8];
      3'd4:    return pat[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] font_width(input logic [3:0] code);
    case (code) inside
      4'd10, 4'd11: return 3'd2;
      default:      return 3'd5;
    endcase
  endfunction

endpackage

// ----- rtl/core/mfgp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mfgp_ram
  import mfgp_pkg::*;
#(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = STORED_ROWS_DEF * WORDS_PER_ROW_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/mono_framebuffer_glyph_plotter.sv -----
// Top level: microcoded framebuffer plotter with glyph ROM and row refresh.
//
//  channel | direction | tdata                               | tuser      | tlast
//  in_     | slave     | opcode, pos_x, pos_y, dot_on, glyph | -          | -
//  out_    | master    | byte_value                          | is_command | last
//
// Each input word runs to the end of its microprogram before the next word is taken:
// plot reads and writes one word; glyph reads each font cell's word and writes it if the
// cell is set and on screen; refresh emits two commands, then two bytes per word; clear
// writes every word, also after reset, with in_tready low. One RAM access a cycle at most.
// A stalled output byte holds the refresh step; the last byte may wait while the
// next input word is taken.
`include "assert_macros.svh"

module mono_framebuffer_glyph_plotter
  import mfgp_pkg::*;
#(
  parameter int STORED_ROWS   = STORED_ROWS_DEF,
  parameter int WORDS_PER_ROW = WORDS_PER_ROW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[1:0], pos_x[8:2], pos_y[14:9], dot_on[15],
                                  // glyph_code[19:16], zero fill[23:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // byte_value[7:0]
  output logic        out_tuser,  // is_command[0]
  output logic        out_tlast
);

  localparam int DEPTH = STORED_ROWS * WORDS_PER_ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int WCW   = $clog2(WORDS_PER_ROW + 1);
  localparam int HALF  = WORDS_PER_ROW / 2;

  // input fields
  op_t        in_op;
  logic [6:0] in_pos_x;
  logic [5:0] in_pos_y;
  logic       in_dot_on;
  logic [3:0] in_glyph;

  assign in_op     = op_t'(in_tdata[1:0]);
  assign in_pos_x  = in_tdata[8:2];
  assign in_pos_y  = in_tdata[14:9];
  assign in_dot_on = in_tdata[15];
  assign in_glyph  = in_tdata[19:16];

  // sequencer and datapath registers
  step_t          pc_r, pc_nxt;
  logic [AW-1:0]  k_r, k_nxt;
  logic [7:0]     base_x_r, base_x_nxt;
  logic [6:0]     base_y_r, base_y_nxt;
  logic           set_r, set_nxt;
  logic [3:0]     code_r, code_nxt;
  logic [2:0]     i_r, i_nxt;
  logic [2:0]     j_r, j_nxt;
  logic [WCW-1:0] w_r, w_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_cmd_r, out_cmd_nxt;
  logic           out_last_r, out_last_nxt;

  ucw_t        cw;
  logic        in_fire;
  logic        can_load;
  logic        out_load;
  logic        jump;

  logic [7:0]  dot_x;
  logic [6:0]  dot_y;
  logic        upper;
  logic [6:0]  dot_row;
  logic [5:0]  dot_word;
  logic        dot_off;
  logic [12:0] dot_addr;
  logic [12:0] row_addr;
  logic [2:0]  gwidth;
  logic [7:0]  frow;
  logic [2:0]  fbit_idx;
  logic        font_bit;
  logic        gly_last;
  logic        glyph_bad;
  logic        row_bad;
  logic        words_more;
  logic        last_word;
  logic [15:0] dot_mask;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  assign cw        = ucode(pc_r);
  assign in_tready = cw.take;
  assign in_fire   = in_tvalid && in_tready;
  assign can_load  = !out_valid_r || out_tready;

  // dot location in the stored layout; lower screen half folds onto the right half
  assign dot_x    = base_x_r + {5'd0, j_r};
  assign dot_y    = base_y_r + {4'd0, i_r};
  assign upper    = dot_y >= 7'(STORED_ROWS);
  assign dot_row  = upper ? dot_y - 7'(STORED_ROWS) : dot_y;
  assign dot_word = {3'd0, dot_x[6:4]} + (upper ? 6'(HALF) : 6'd0);
  assign dot_off  = dot_x[7] || (dot_row >= 7'(STORED_ROWS)) ||
                    (dot_word >= 6'(WORDS_PER_ROW));
  assign dot_addr = 13'(dot_row) * 13'(WORDS_PER_ROW) + 13'(dot_word);
  assign row_addr = 13'(base_y_r) * 13'(WORDS_PER_ROW) + 13'(w_r);
  assign dot_mask = DOT_MSB_MASK >> dot_x[3:0];

  assign gwidth    = font_width(code_r);
  assign frow      = font_row(code_r, i_r);
  assign fbit_idx  = gwidth - 3'd1 - j_r;
  assign font_bit  = frow[fbit_idx];
  assign gly_last  = (i_r == 3'(GLYPH_ROWS - 1)) && (j_r == gwidth - 3'd1);
  assign glyph_bad = code_r >= 4'(GLYPH_COUNT);
  assign row_bad   = base_y_r >= 7'(STORED_ROWS);
  assign words_more = w_r != WCW'(WORDS_PER_ROW);
  assign last_word  = w_r == WCW'(WORDS_PER_ROW - 1);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_DISPATCH:   jump = in_fire;
      C_CLR_MORE:   jump = k_r != AW'(DEPTH - 1);
      C_DOT_OFF:    jump = dot_off;
      C_BAD_GLYPH:  jump = glyph_bad;
      C_DOT_SKIP:   jump = dot_off || !font_bit;
      C_GLY_MORE:   jump = !gly_last;
      C_ROW_BAD:    jump = row_bad;
      C_OUT_BUSY:   jump = !can_load;
      C_WORDS_MORE: jump = words_more;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (cw.cond == C_DISPATCH) begin
      pc_nxt = in_fire ? dispatch(in_op) : pc_r;
    end else begin
      pc_nxt = jump ? cw.target : pc_r + step_t'(1);
    end
  end

  // RAM port control
  always_comb begin
    ram_we    = (cw.act == ACT_CLR) || (cw.act == ACT_WR_DOT);
    ram_waddr = (cw.act == ACT_CLR) ? k_r : dot_addr[AW-1:0];
    if (cw.act == ACT_CLR) begin
      ram_wdata = '0;
    end else if (set_r) begin
      ram_wdata = ram_rdata | dot_mask;
    end else begin
      ram_wdata = ram_rdata & ~dot_mask;
    end
    ram_re    = (cw.act == ACT_RD_DOT) || (cw.act == ACT_RD_WORD);
    ram_raddr = (cw.act == ACT_RD_WORD) ? row_addr[AW-1:0] : dot_addr[AW-1:0];
  end

  assign out_load = can_load && ((cw.act == ACT_EMIT_ROW) || (cw.act == ACT_EMIT_COL) ||
                                 (cw.act == ACT_EMIT_HI) || (cw.act == ACT_EMIT_LO));

  always_comb begin
    k_nxt      = k_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    set_nxt    = set_r;
    code_nxt   = code_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    w_nxt      = w_r;
    if (in_fire) begin
      k_nxt      = '0;
      base_x_nxt = {1'b0, in_pos_x};
      base_y_nxt = {1'b0, in_pos_y};
      set_nxt    = (in_op == OP_PLOT) ? in_dot_on : 1'b1;
      code_nxt   = in_glyph;
      i_nxt      = '0;
      j_nxt      = '0;
      w_nxt      = '0;
    end
    if (cw.act == ACT_CLR) begin
      k_nxt = k_r + AW'(1);
    end
    if (cw.act == ACT_GLY_ADV) begin
      // advance along the font row, then wrap to the next row
      if (j_r == gwidth - 3'd1) begin
        j_nxt = '0;
        i_nxt = i_r + 3'd1;
      end else begin
        j_nxt = j_r + 3'd1;
      end
    end
    if (out_load && (cw.act == ACT_EMIT_LO)) begin
      w_nxt = w_r + WCW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_cmd_nxt   = out_cmd_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      case (cw.act)
        ACT_EMIT_ROW: begin
          out_byte_nxt = CMD_ROW_BASE | {2'b00, base_y_r[5:0]};
          out_cmd_nxt  = 1'b1;
        end
        ACT_EMIT_COL: begin
          out_byte_nxt = CMD_COL_ZERO;
          out_cmd_nxt  = 1'b1;
        end
        ACT_EMIT_HI: begin
          out_byte_nxt = ram_rdata[15:8];
          out_cmd_nxt  = 1'b0;
        end
        default: begin
          out_byte_nxt = ram_rdata[7:0];
          out_cmd_nxt  = 1'b0;
          out_last_nxt = last_word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_CLR;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_x_r   <= base_x_nxt;
    base_y_r   <= base_y_nxt;
    set_r      <= set_nxt;
    code_r     <= code_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    w_r        <= w_nxt;
    out_byte_r <= out_byte_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_last_r <= out_last_nxt;
  end

  mfgp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_cmd_r;
  assign out_tlast  = out_last_r;

  `MFGP_ASSERT_ALWAYS(a_ram_one_access, !(ram_we && ram_re), "RAM read and write in one cycle")
  `MFGP_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "ready after take")
  `MFGP_ASSERT_SAME(a_no_emit_in_clear, ram_we, !out_load, "byte emitted during a write")

endmodule

// ----- tb/mono_framebuffer_glyph_plotter_tb.sv -----
// Self-checking testbench for the framebuffer glyph plotter: directed table, then random commands.
module mono_framebuffer_glyph_plotter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfgp_pkg::*;

  localparam int SCREEN_W    = 128;
  localparam int GLYPH_DOT   = 10;
  localparam int GLYPH_COLON = 11;
  localparam int GLYPH_SPACE = 12;
  localparam int GLYPH_BAD   = 15;
  localparam int DRAIN_CYCLES = 600;

  // Five 5-bit rows per glyph, top row first; glyph 0 in the highest bits.
  localparam logic [GLYPH_COUNT*25-1:0] GLYPH_DOTS = {
    {5'h06, 5'h09, 5'h09, 5'h09, 5'h06},
    {5'h02, 5'h06, 5'h02, 5'h02, 5'h07},
    {5'h06, 5'h09, 5'h02, 5'h04, 5'h0F},
    {5'h06, 5'h09, 5'h02, 5'h09, 5'h06},
    {5'h02, 5'h06, 5'h0A, 5'h0F, 5'h02},
    {5'h0E, 5'h08, 5'h0E, 5'h01, 5'h0E},
    {5'h06, 5'h08, 5'h0E, 5'h09, 5'h06},
    {5'h0F, 5'h01, 5'h02, 5'h04, 5'h04},
    {5'h06, 5'h09, 5'h06, 5'h09, 5'h06},
    {5'h06, 5'h09, 5'h07, 5'h01, 5'h06},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h01},
    {5'h00, 5'h01, 5'h00, 5'h01, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] val;
    logic       last;
  } lcd_byte_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] x;
    logic [5:0] y;
    logic       dot;
    logic [3:0] glyph;
    logic       known;   // expected bytes typed in below
    logic [7:0] fill;    // every data byte of a known refresh
  } plot_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  logic [15:0] frame_img [STORED_ROWS_DEF][WORDS_PER_ROW_DEF];
  lcd_byte_t   pending_bytes [$];

  plot_row_t directed_rows [24] = '{
    '{OP_REFRESH, 7'd0,   6'd0,  1'b0, 4'd0,  1'b1, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd31, 1'b0, 4'd0,  1'b1, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd32, 1'b0, 4'd0,  1'b1, 8'h00},
    '{OP_REFRESH, 7'd127, 6'd63, 1'b1, 4'd15, 1'b1, 8'h00},
    '{OP_PLOT,    7'd0,   6'd0,  1'b1, 4'd0,  1'b0, 8'h00},
    '{OP_PLOT,    7'd127, 6'd63, 1'b1, 4'd0,  1'b0, 8'h00},
    '{OP_PLOT,    7'd127, 6'd0,  1'b1, 4'd0,  1'b0, 8'h00},
    '{OP_PLOT,    7'd0,   6'd32, 1'b1, 4'd0,  1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd0,  1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd31, 1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_PLOT,    7'd0,   6'd0,  1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_GLYPH,   7'd124, 6'd60, 1'b0, 4'd8,  1'b0, 8'h00},
    '{OP_GLYPH,   7'd126, 6'd30, 1'b0, GLYPH_DOT[3:0],   1'b0, 8'h00},
    '{OP_GLYPH,   7'd5,   6'd3,  1'b0, GLYPH_COLON[3:0], 1'b0, 8'h00},
    '{OP_GLYPH,   7'd0,   6'd0,  1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_GLYPH,   7'd40,  6'd10, 1'b1, GLYPH_BAD[3:0],   1'b0, 8'h00},
    '{OP_GLYPH,   7'd64,  6'd0,  1'b0, GLYPH_SPACE[3:0], 1'b0, 8'h00},
    '{OP_GLYPH,   7'd60,  6'd27, 1'b0, 4'd4,  1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd0,  1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd3,  1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd30, 1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd31, 1'b0, 4'd0,  1'b0, 8'h00},
    '{OP_CLEAR,   7'd85,  6'd42, 1'b1, 4'd10, 1'b0, 8'h00},
    '{OP_REFRESH, 7'd0,   6'd31, 1'b0, 4'd0,  1'b1, 8'h00}
  };

  mono_framebuffer_glyph_plotter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("mono_framebuffer_glyph_plotter_tb: done, errors");
    $finish;
  end

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, what);
  endtask

  task automatic push_byte(input logic cmd, input logic [7:0] val, input logic last);
    lcd_byte_t b;
    b.cmd  = cmd;
    b.val  = val;
    b.last = last;
    pending_bytes.push_back(b);
  endtask

  task automatic push_row_header(input logic [5:0] row);
    push_byte(1'b1, CMD_ROW_BASE | {2'b00, row}, 1'b0);
    push_byte(1'b1, CMD_COL_ZERO, 1'b0);
  endtask

  task automatic poke_pixel(input int x, input int y, input logic on);
    int row;
    int word;
    logic [15:0] mask;
    if (x >= SCREEN_W) return;
    if (y >= STORED_ROWS_DEF) begin
      row  = y - STORED_ROWS_DEF;
      word = x / 16 + WORDS_PER_ROW_DEF / 2;
    end else begin
      row  = y;
      word = x / 16;
    end
    if (row >= STORED_ROWS_DEF || word >= WORDS_PER_ROW_DEF) return;
    mask = DOT_MSB_MASK >> (x % 16);
    if (on) frame_img[row][word] = frame_img[row][word] | mask;
    else frame_img[row][word] = frame_img[row][word] & ~mask;
  endtask

  // Update the frame image and queue the bytes one command produces.
  task automatic run_plotter_cmd(input op_t op, input logic [6:0] x, input logic [5:0] y,
                                 input logic dot, input logic [3:0] glyph);
    int width;
    logic [4:0] bits;
    case (op)
      OP_CLEAR: begin
        foreach (frame_img[r, w]) frame_img[r][w] = '0;
      end
      OP_PLOT: poke_pixel(x, y, dot);
      OP_GLYPH: begin
        if (glyph < GLYPH_COUNT) begin
          width = (glyph == GLYPH_DOT || glyph == GLYPH_COLON) ? 2 : 5;
          for (int i = 0; i < GLYPH_ROWS; i++) begin
            bits = GLYPH_DOTS[(GLYPH_COUNT - 1 - glyph) * 25 + (4 - i) * 5 +: 5];
            // narrow glyphs use the low bits, so the leftmost column tests bit width-1
            for (int j = 0; j < width; j++)
              if (bits[width - 1 - j]) poke_pixel(x + j, y + i, 1'b1);
          end
        end
      end
      OP_REFRESH: begin
        if (y < STORED_ROWS_DEF) begin
          push_row_header(y);
          for (int w = 0; w < WORDS_PER_ROW_DEF; w++) begin
            push_byte(1'b0, frame_img[y][w][15:8], 1'b0);
            push_byte(1'b0, frame_img[y][w][7:0], w == WORDS_PER_ROW_DEF - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input op_t op, input logic [6:0] x, input logic [5:0] y,
                          input logic dot, input logic [3:0] glyph);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0000, glyph, dot, y, x, op};
        placed = 1'b1;
      end
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : watch_bytes
    lcd_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected word cmd=%0b byte=%02h last=%0b",
                                out_tuser, out_tdata, out_tlast));
      end else begin
        want = pending_bytes.pop_front();
        if (out_tuser !== want.cmd || out_tdata !== want.val || out_tlast !== want.last)
          note_mismatch($sformatf({"expected cmd=%0b byte=%02h last=%0b, ",
                                   "got cmd=%0b byte=%02h last=%0b"},
                                  want.cmd, want.val, want.last,
                                  out_tuser, out_tdata, out_tlast));
      end
    end
  end

  initial begin
    plot_row_t   pr;
    op_t         op;
    logic [6:0]  x;
    logic [5:0]  y;
    logic        dot;
    logic [3:0]  glyph;
    int          pick;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    foreach (frame_img[r, w]) frame_img[r][w] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 65;
    foreach (directed_rows[i]) begin
      pr = directed_rows[i];
      send_cmd(pr.op, pr.x, pr.y, pr.dot, pr.glyph);
      if (pr.known) begin
        // rows above the stored range produce nothing
        if (pr.y < STORED_ROWS_DEF) begin
          push_row_header(pr.y);
          for (int w = 0; w < 2 * WORDS_PER_ROW_DEF; w++)
            push_byte(1'b0, pr.fill, w == 2 * WORDS_PER_ROW_DEF - 1);
        end
      end else begin
        run_plotter_cmd(pr.op, pr.x, pr.y, pr.dot, pr.glyph);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 28; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (32) begin
        pick  = $urandom_range(99);
        x     = 7'($urandom_range(127));
        y     = 6'($urandom_range(63));
        dot   = 1'($urandom_range(1));
        glyph = 4'($urandom_range(15));
        if (pick < 5) op = OP_CLEAR;
        else if (pick < 45) op = OP_PLOT;
        else if (pick < 72) op = OP_GLYPH;
        else begin
          op = OP_REFRESH;
          // mostly real rows, now and then one past the stored range
          y = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 32)) : 6'($urandom_range(31));
        end
        send_cmd(op, x, y, dot, glyph);
        run_plotter_cmd(op, x, y, dot, glyph);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("mono_framebuffer_glyph_plotter_tb: done, clean");
    end else begin
      $display("mono_framebuffer_glyph_plotter_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mfgp_pkg.sv
rtl/core/mfgp_ram.sv
rtl/core/mono_framebuffer_glyph_plotter.sv
tb/mono_framebuffer_glyph_plotter_tb.sv
